FILE: hdl/rqi_pkg.sv
`timescale 1ns / 1ps

package rqi_pkg;

    // Field widths
    localparam int COORD_W = 20;
    localparam int FRAC_W  = 12;
    localparam int TLIM_W  = 19;
    localparam int COEF_W  = 13;
    localparam int OFFS_W  = 24;
    localparam int EPS_W   = 12;
    localparam int VEC_W   = 3 * COORD_W;

    // Configuration port
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_CORNER = 3'd0;
    localparam logic [IDX_W-1:0] REG_EDGE_U = 3'd1;
    localparam logic [IDX_W-1:0] REG_EDGE_V = 3'd2;
    localparam logic [IDX_W-1:0] REG_NORMAL = 3'd3;
    localparam logic [IDX_W-1:0] REG_OFFSET = 3'd4;
    localparam logic [IDX_W-1:0] REG_WNORM  = 3'd5;
    localparam logic [IDX_W-1:0] REG_EPS    = 3'd6;

    // Datapath widths
    localparam int PROD_W = 2 * COORD_W;            // coord x coord
    localparam int DEN_W  = PROD_W + 2;             // sum of three products
    localparam int NUM_W  = PROD_W + 3;             // offset minus dot
    localparam int DSR_W  = DEN_W;
    localparam int Q_W    = TLIM_W;
    localparam int REM_W  = DSR_W + Q_W + 1;

    // 0.001 rounded to the nearest lsb
    localparam int MIN_T  = ((1 << FRAC_W) * 1000 + 500000) / 1000000;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    // Item context carried alongside the divider
    typedef struct packed {
        vec_t              org;
        vec_t              dir;
        logic [TLIM_W-1:0] tlim;
        logic              miss;
    } ray_ctx_t;

    function automatic vec_t unpack_vec(input logic [VEC_W-1:0] r);
        vec_t v;
        v.x = r[COORD_W-1:0];
        v.y = r[2*COORD_W-1:COORD_W];
        v.z = r[3*COORD_W-1:2*COORD_W];
        return v;
    endfunction

endpackage

FILE: hdl/rqi_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, most significant first.
// Expects the dividend below divisor << Q_W.
module rqi_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [rqi_pkg::REM_W-1:0] in_rem,
    input  logic [rqi_pkg::DSR_W-1:0] in_dsr,
    input  rqi_pkg::ray_ctx_t         in_ctx,
    output logic                      out_valid,
    output logic [rqi_pkg::Q_W-1:0]   out_q,
    output rqi_pkg::ray_ctx_t         out_ctx
);
    import rqi_pkg::*;

    logic             vld_reg [1:Q_W];
    logic [REM_W-1:0] rem_reg [1:Q_W];
    logic [DSR_W-1:0] dsr_reg [1:Q_W];
    logic [Q_W-1:0]   q_reg   [1:Q_W];
    ray_ctx_t         ctx_reg [1:Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stg
        localparam int BIT = Q_W - 1 - k;
        logic             vld_src;
        logic [REM_W-1:0] rem_src;
        logic [DSR_W-1:0] dsr_src;
        logic [Q_W-1:0]   q_src;
        ray_ctx_t         ctx_src;
        logic [REM_W-1:0] sub;
        logic             take;

        if (k == 0) begin : g_first
            assign vld_src = in_valid;
            assign rem_src = in_rem;
            assign dsr_src = in_dsr;
            assign q_src   = '0;
            assign ctx_src = in_ctx;
        end
        else begin : g_next
            assign vld_src = vld_reg[k];
            assign rem_src = rem_reg[k];
            assign dsr_src = dsr_reg[k];
            assign q_src   = q_reg[k];
            assign ctx_src = ctx_reg[k];
        end

        assign sub  = REM_W'(dsr_src) << BIT;
        assign take = rem_src >= sub;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= take ? rem_src - sub : rem_src;
            dsr_reg[k+1] <= dsr_src;
            q_reg[k+1]   <= take ? (q_src | (Q_W'(1) << BIT)) : q_src;
            ctx_reg[k+1] <= ctx_src;
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign out_q     = q_reg[Q_W];
    assign out_ctx   = ctx_reg[Q_W];

endmodule

FILE: hdl/ray_quad_intersect.sv
`timescale 1ns / 1ps
// Ray against parallelogram intersector, fixed-point pipeline.
// Throughput: one item per cycle; busy is always low, the 19-stage divider sets depth.
// Reset: rst_n clears all valid bits and loads the default quad (unit square at z = 0).
// Results are not held: the receiver must take done on the cycle it pulses.
module ray_quad_intersect (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB-style configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rqi_pkg::ADDR_W-1:0]  paddr,
    input  logic [rqi_pkg::DATA_W-1:0]  pwdata,
    output logic [rqi_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Command side
    input  logic                        start,
    output logic                        busy,
    input  logic signed [rqi_pkg::COORD_W-1:0] ray_origin_x,
    input  logic signed [rqi_pkg::COORD_W-1:0] ray_origin_y,
    input  logic signed [rqi_pkg::COORD_W-1:0] ray_origin_z,
    input  logic signed [rqi_pkg::COORD_W-1:0] ray_dir_x,
    input  logic signed [rqi_pkg::COORD_W-1:0] ray_dir_y,
    input  logic signed [rqi_pkg::COORD_W-1:0] ray_dir_z,
    input  logic [rqi_pkg::TLIM_W-1:0]         t_limit,
    // Result side
    output logic                        done,
    output logic                        hit,
    output logic [rqi_pkg::TLIM_W-1:0]  hit_distance,
    output logic [rqi_pkg::COEF_W-1:0]  coord_alpha,
    output logic [rqi_pkg::COEF_W-1:0]  coord_beta,
    output logic signed [rqi_pkg::COORD_W-1:0] point_x,
    output logic signed [rqi_pkg::COORD_W-1:0] point_y,
    output logic signed [rqi_pkg::COORD_W-1:0] point_z
);
    import rqi_pkg::*;

    // Hit point and offset widths
    localparam int TD_W = PROD_W;                  // t * d
    localparam int P_W  = TD_W - FRAC_W + 1;       // o + floor(t*d)
    localparam int PQ_W = P_W + 1;                 // p - corner
    localparam int XP_W = PQ_W + COORD_W;          // pq x edge product
    localparam int CR_W = XP_W + 1 - FRAC_W;       // floored cross term
    localparam int WP_W = CR_W + COORD_W;          // W . cross product
    localparam int SM_W = WP_W + 2;                // three-term sum
    localparam int CO_W = SM_W - FRAC_W;           // floored coordinate

    localparam logic signed [P_W-1:0]  P_HI = P_W'((1 <<< (COORD_W - 1)) - 1);
    localparam logic signed [P_W-1:0]  P_LO = -P_W'(1 <<< (COORD_W - 1));
    localparam logic signed [CO_W-1:0] CO_ONE = CO_W'(1 <<< FRAC_W);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [VEC_W-1:0]         corner_reg;
    logic [VEC_W-1:0]         edge_u_reg;
    logic [VEC_W-1:0]         edge_v_reg;
    logic [VEC_W-1:0]         normal_reg;
    logic signed [OFFS_W-1:0] offset_reg;
    logic [VEC_W-1:0]         wnorm_reg;
    logic [EPS_W-1:0]         eps_reg;

    logic [IDX_W-1:0] cfg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= '0;
            edge_u_reg <= VEC_W'(1) << FRAC_W;
            edge_v_reg <= VEC_W'(1) << (FRAC_W + COORD_W);
            normal_reg <= VEC_W'(1) << (FRAC_W + 2 * COORD_W);
            offset_reg <= '0;
            wnorm_reg  <= VEC_W'(1) << (FRAC_W + 2 * COORD_W);
            eps_reg    <= EPS_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_CORNER: corner_reg <= pwdata[VEC_W-1:0];
                REG_EDGE_U: edge_u_reg <= pwdata[VEC_W-1:0];
                REG_EDGE_V: edge_v_reg <= pwdata[VEC_W-1:0];
                REG_NORMAL: normal_reg <= pwdata[VEC_W-1:0];
                REG_OFFSET: offset_reg <= pwdata[OFFS_W-1:0];
                REG_WNORM:  wnorm_reg  <= pwdata[VEC_W-1:0];
                REG_EPS:    eps_reg    <= pwdata[EPS_W-1:0];
                default:    ;  // no register here: drop the write
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_CORNER: prdata = DATA_W'(corner_reg);
            REG_EDGE_U: prdata = DATA_W'(edge_u_reg);
            REG_EDGE_V: prdata = DATA_W'(edge_v_reg);
            REG_NORMAL: prdata = DATA_W'(normal_reg);
            REG_OFFSET: prdata = DATA_W'(unsigned'(offset_reg));
            REG_WNORM:  prdata = DATA_W'(wnorm_reg);
            REG_EPS:    prdata = DATA_W'(eps_reg);
            default:    prdata = '0;
        endcase
    end

    // The user must change config only while idle; the block does not enforce this, and the stages read it live.
    vec_t q_v, u_v, v_v, n_v, w_v;
    assign q_v = unpack_vec(corner_reg);
    assign u_v = unpack_vec(edge_u_reg);
    assign v_v = unpack_vec(edge_v_reg);
    assign n_v = unpack_vec(normal_reg);
    assign w_v = unpack_vec(wnorm_reg);

    // Never stalls: a new item every cycle.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: N.d and N.o products
    // ------------------------------------------------------------------
    logic                     s1_vld_reg;
    logic signed [PROD_W-1:0] s1_dn_reg [3];
    logic signed [PROD_W-1:0] s1_no_reg [3];
    vec_t                     s1_org_reg, s1_dir_reg;
    logic [TLIM_W-1:0]        s1_tlim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dn_reg[0] <= PROD_W'(ray_dir_x) * PROD_W'(n_v.x);
        s1_dn_reg[1] <= PROD_W'(ray_dir_y) * PROD_W'(n_v.y);
        s1_dn_reg[2] <= PROD_W'(ray_dir_z) * PROD_W'(n_v.z);
        s1_no_reg[0] <= PROD_W'(ray_origin_x) * PROD_W'(n_v.x);
        s1_no_reg[1] <= PROD_W'(ray_origin_y) * PROD_W'(n_v.y);
        s1_no_reg[2] <= PROD_W'(ray_origin_z) * PROD_W'(n_v.z);
        s1_org_reg   <= '{x: ray_origin_x, y: ray_origin_y, z: ray_origin_z};
        s1_dir_reg   <= '{x: ray_dir_x, y: ray_dir_y, z: ray_dir_z};
        s1_tlim_reg  <= t_limit;
    end

    // ------------------------------------------------------------------
    // Stage 2: sums, magnitudes, parallel and sign rejection
    // ------------------------------------------------------------------
    logic signed [DEN_W-1:0] den;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den_abs;
    logic [NUM_W-1:0]        num_abs;
    logic                    s2_miss;

    always_comb
    begin
        den = DEN_W'(s1_dn_reg[0]) + DEN_W'(s1_dn_reg[1]) + DEN_W'(s1_dn_reg[2]);
        num = (NUM_W'(offset_reg) <<< FRAC_W)
              - NUM_W'(s1_no_reg[0]) - NUM_W'(s1_no_reg[1]) - NUM_W'(s1_no_reg[2]);
        den_abs = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        // Parallel, or t <= 0 (zero numerator or opposite signs): both miss.
        s2_miss = (den == '0)
               || (den_abs < DEN_W'({eps_reg, FRAC_W'(0)}))
               || (num == '0)
               || (num[NUM_W-1] != den[DEN_W-1]);
    end

    logic             s2_vld_reg;
    logic [DEN_W-1:0] s2_den_reg;
    logic [NUM_W-1:0] s2_num_reg;
    ray_ctx_t         s2_ctx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_den_reg <= den_abs;
        s2_num_reg <= num_abs;
        s2_ctx_reg <= '{org: s1_org_reg, dir: s1_dir_reg, tlim: s1_tlim_reg,
                        miss: s2_miss};
    end

    // ------------------------------------------------------------------
    // Stage 3: overflow screen; quotients at or above 2^Q_W exceed any limit
    // ------------------------------------------------------------------
    logic [REM_W-1:0] dvd;
    logic [REM_W-1:0] dvd_lim;
    ray_ctx_t         s3_ctx;

    always_comb
    begin
        dvd     = REM_W'(s2_num_reg) << FRAC_W;
        dvd_lim = REM_W'(s2_den_reg) << Q_W;
        s3_ctx  = s2_ctx_reg;
        s3_ctx.miss = s2_ctx_reg.miss || (dvd >= dvd_lim);
    end

    logic             s3_vld_reg;
    logic [REM_W-1:0] s3_dvd_reg;
    logic [DSR_W-1:0] s3_dsr_reg;
    ray_ctx_t         s3_ctx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // Hold a missed item's dividend at zero so the divider stays in range.
        s3_dvd_reg <= s3_ctx.miss ? '0 : dvd;
        s3_dsr_reg <= s2_den_reg;
        s3_ctx_reg <= s3_ctx;
    end

    // ------------------------------------------------------------------
    // Divider: t = |num| * 2^F / |den|
    // ------------------------------------------------------------------
    logic             dv_vld;
    logic [Q_W-1:0]   dv_q;
    ray_ctx_t         dv_ctx;

    rqi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_vld_reg),
        .in_rem    (s3_dvd_reg),
        .in_dsr    (s3_dsr_reg),
        .in_ctx    (s3_ctx_reg),
        .out_valid (dv_vld),
        .out_q     (dv_q),
        .out_ctx   (dv_ctx)
    );

    // ------------------------------------------------------------------
    // Stage 4: range check on t, t * d products
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] t_s;
    assign t_s = $signed({1'b0, dv_q});

    logic                   s4_vld_reg;
    logic                   s4_miss_reg;
    logic [Q_W-1:0]         s4_t_reg;
    vec_t                   s4_org_reg;
    logic signed [TD_W-1:0] s4_td_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s4_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_miss_reg  <= dv_ctx.miss || (dv_q < Q_W'(MIN_T)) || (dv_q > dv_ctx.tlim);
        s4_t_reg     <= dv_q;
        s4_org_reg   <= dv_ctx.org;
        s4_td_reg[0] <= TD_W'(t_s) * TD_W'(dv_ctx.dir.x);
        s4_td_reg[1] <= TD_W'(t_s) * TD_W'(dv_ctx.dir.y);
        s4_td_reg[2] <= TD_W'(t_s) * TD_W'(dv_ctx.dir.z);
    end

    // ------------------------------------------------------------------
    // Stage 5: hit point, offset from corner, saturated point
    // ------------------------------------------------------------------
    logic signed [P_W-1:0] p_c [3];
    logic signed [PQ_W-1:0] pq_c [3];
    logic signed [COORD_W-1:0] o_c [3];
    logic signed [COORD_W-1:0] q_c [3];
    logic signed [COORD_W-1:0] ps_c [3];

    always_comb
    begin
        o_c[0] = s4_org_reg.x;
        o_c[1] = s4_org_reg.y;
        o_c[2] = s4_org_reg.z;
        q_c[0] = q_v.x;
        q_c[1] = q_v.y;
        q_c[2] = q_v.z;
        for (int k = 0; k < 3; k++)
        begin
            p_c[k]  = P_W'(o_c[k]) + P_W'(s4_td_reg[k] >>> FRAC_W);
            pq_c[k] = PQ_W'(p_c[k]) - PQ_W'(q_c[k]);
            if (p_c[k] > P_HI)
            begin
                ps_c[k] = COORD_W'(P_HI);
            end
            else if (p_c[k] < P_LO)
            begin
                ps_c[k] = COORD_W'(P_LO);
            end
            else
            begin
                ps_c[k] = p_c[k][COORD_W-1:0];
            end
        end
    end

    logic                      s5_vld_reg;
    logic                      s5_miss_reg;
    logic [Q_W-1:0]            s5_t_reg;
    logic signed [PQ_W-1:0]    s5_pq_reg [3];
    logic signed [COORD_W-1:0] s5_pt_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_miss_reg <= s4_miss_reg;
        s5_t_reg    <= s4_t_reg;
        s5_pq_reg   <= pq_c;
        s5_pt_reg   <= ps_c;
    end

    // ------------------------------------------------------------------
    // Stage 6: cross product terms, pq x V for alpha and U x pq for beta
    // ------------------------------------------------------------------
    logic                      s6_vld_reg;
    logic                      s6_miss_reg;
    logic [Q_W-1:0]            s6_t_reg;
    logic signed [COORD_W-1:0] s6_pt_reg [3];
    logic signed [XP_W-1:0]    s6_ap_reg [3][2];
    logic signed [XP_W-1:0]    s6_bp_reg [3][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_vld_reg <= 1'b0;
        end
        else
        begin
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_miss_reg <= s5_miss_reg;
        s6_t_reg    <= s5_t_reg;
        s6_pt_reg   <= s5_pt_reg;
        s6_ap_reg[0][0] <= XP_W'(s5_pq_reg[1]) * XP_W'(v_v.z);
        s6_ap_reg[0][1] <= XP_W'(s5_pq_reg[2]) * XP_W'(v_v.y);
        s6_ap_reg[1][0] <= XP_W'(s5_pq_reg[2]) * XP_W'(v_v.x);
        s6_ap_reg[1][1] <= XP_W'(s5_pq_reg[0]) * XP_W'(v_v.z);
        s6_ap_reg[2][0] <= XP_W'(s5_pq_reg[0]) * XP_W'(v_v.y);
        s6_ap_reg[2][1] <= XP_W'(s5_pq_reg[1]) * XP_W'(v_v.x);
        s6_bp_reg[0][0] <= XP_W'(u_v.y) * XP_W'(s5_pq_reg[2]);
        s6_bp_reg[0][1] <= XP_W'(u_v.z) * XP_W'(s5_pq_reg[1]);
        s6_bp_reg[1][0] <= XP_W'(u_v.z) * XP_W'(s5_pq_reg[0]);
        s6_bp_reg[1][1] <= XP_W'(u_v.x) * XP_W'(s5_pq_reg[2]);
        s6_bp_reg[2][0] <= XP_W'(u_v.x) * XP_W'(s5_pq_reg[1]);
        s6_bp_reg[2][1] <= XP_W'(u_v.y) * XP_W'(s5_pq_reg[0]);
    end

    // ------------------------------------------------------------------
    // Stage 7: floor the cross products to Q.F
    // ------------------------------------------------------------------
    logic                      s7_vld_reg;
    logic                      s7_miss_reg;
    logic [Q_W-1:0]            s7_t_reg;
    logic signed [COORD_W-1:0] s7_pt_reg [3];
    logic signed [CR_W-1:0]    s7_ac_reg [3];
    logic signed [CR_W-1:0]    s7_bc_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_vld_reg <= 1'b0;
        end
        else
        begin
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s7_miss_reg <= s6_miss_reg;
        s7_t_reg    <= s6_t_reg;
        s7_pt_reg   <= s6_pt_reg;
        for (int k = 0; k < 3; k++)
        begin
            s7_ac_reg[k] <= CR_W'(((XP_W+1)'(s6_ap_reg[k][0])
                                   - (XP_W+1)'(s6_ap_reg[k][1])) >>> FRAC_W);
            s7_bc_reg[k] <= CR_W'(((XP_W+1)'(s6_bp_reg[k][0])
                                   - (XP_W+1)'(s6_bp_reg[k][1])) >>> FRAC_W);
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: W . cross products
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] w_c [3];
    assign w_c[0] = w_v.x;
    assign w_c[1] = w_v.y;
    assign w_c[2] = w_v.z;

    logic                      s8_vld_reg;
    logic                      s8_miss_reg;
    logic [Q_W-1:0]            s8_t_reg;
    logic signed [COORD_W-1:0] s8_pt_reg [3];
    logic signed [WP_W-1:0]    s8_aw_reg [3];
    logic signed [WP_W-1:0]    s8_bw_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_vld_reg <= 1'b0;
        end
        else
        begin
            s8_vld_reg <= s7_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s8_miss_reg <= s7_miss_reg;
        s8_t_reg    <= s7_t_reg;
        s8_pt_reg   <= s7_pt_reg;
        for (int k = 0; k < 3; k++)
        begin
            s8_aw_reg[k] <= WP_W'(w_c[k]) * WP_W'(s7_ac_reg[k]);
            s8_bw_reg[k] <= WP_W'(w_c[k]) * WP_W'(s7_bc_reg[k]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: sum, floor, bounds check, output register
    // ------------------------------------------------------------------
    logic signed [CO_W-1:0] alpha, beta;
    logic                   inside_quad;

    always_comb
    begin
        alpha = CO_W'((SM_W'(s8_aw_reg[0]) + SM_W'(s8_aw_reg[1]) + SM_W'(s8_aw_reg[2]))
                      >>> FRAC_W);
        beta  = CO_W'((SM_W'(s8_bw_reg[0]) + SM_W'(s8_bw_reg[1]) + SM_W'(s8_bw_reg[2]))
                      >>> FRAC_W);
        inside_quad = !alpha[CO_W-1] && (alpha <= CO_ONE)
                   && !beta[CO_W-1]  && (beta <= CO_ONE);
    end

    logic                      done_reg;
    logic                      hit_reg;
    logic [TLIM_W-1:0]         dist_reg;
    logic [COEF_W-1:0]         alpha_reg, beta_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic                      is_hit;

    assign is_hit = !s8_miss_reg && inside_quad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s8_vld_reg;
        end
    end

    // Zero every field on a miss.
    always_ff @(posedge clk)
    begin
        hit_reg   <= is_hit;
        dist_reg  <= is_hit ? s8_t_reg : '0;
        alpha_reg <= is_hit ? alpha[COEF_W-1:0] : '0;
        beta_reg  <= is_hit ? beta[COEF_W-1:0] : '0;
        px_reg    <= is_hit ? s8_pt_reg[0] : '0;
        py_reg    <= is_hit ? s8_pt_reg[1] : '0;
        pz_reg    <= is_hit ? s8_pt_reg[2] : '0;
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign hit_distance = dist_reg;
    assign coord_alpha  = alpha_reg;
    assign coord_beta   = beta_reg;
    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign point_z      = pz_reg;

endmodule
